// ----- rtl/core/itsamp_pkg.sv -----
// Shared constants, codes and types of the table inverse-transform sampler.
package itsamp_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int CMD_W    = 2;
   localparam int ENTRY_W  = 17;
   localparam int DRAW_W   = 16;
   localparam int STEP_W   = 32;
   localparam int TIME_W   = 42;
   localparam int STATUS_W = 2;

   localparam int PROD_W    = ENTRY_W + STEP_W;
   localparam int QUO_W     = PROD_W + (PROD_W % 2);
   localparam int DIV_STEPS = QUO_W / 2;
   localparam int DCNT_W    = $clog2(DIV_STEPS);
   localparam int SUM_W     = PROD_W + 1;

   localparam logic [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(65536);
   localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = CSR_IDX_W'(0);
   localparam logic [STEP_W-1:0]    STEP_RESET    = STEP_W'(65536);

   typedef enum logic [CMD_W-1:0] {
      CMD_RESTART = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_SAMPLE  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_DECR   = 2'd1,
      STATUS_FULL       = 2'd2,
      STATUS_BAD_TABLE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SRCH,
      S_INTERP,
      S_BASE,
      S_DSTART,
      S_DIV,
      S_SUM,
      S_CLAMP,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      ARITH_NOP,
      ARITH_MUL,
      ARITH_DIV_START,
      ARITH_DIV_STEP
   } arith_op_type;

   typedef struct packed {
      arith_op_type       op;
      logic [ENTRY_W-1:0] mul_a;
      logic [ENTRY_W-1:0] divisor;
   } arith_cmd_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [QUO_W-1:0]  quo;
   } arith_res_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_req_type;

   function automatic logic [TIME_W-1:0] clamp_time(input logic [SUM_W-1:0] x);
      if (x > SUM_W'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return x[TIME_W-1:0];
   endfunction

endpackage

// ----- rtl/core/itsamp_req_if.sv -----
// Request channel: command, table entry and uniform draw with valid/ready.
interface itsamp_req_if;
   import itsamp_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [ENTRY_W-1:0]  entry_value;
   logic [DRAW_W-1:0]   uniform_draw;

   modport source (output valid, cmd, entry_value, uniform_draw, input ready);
   modport sink   (input valid, cmd, entry_value, uniform_draw, output ready);
endinterface

// ----- rtl/core/itsamp_rsp_if.sv -----
// Response channel: sampled time and status with valid/ready.
interface itsamp_rsp_if;
   import itsamp_pkg::*;

   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   sample_time;
   logic [STATUS_W-1:0] status;

   modport source (output valid, sample_time, status, input ready);
   modport sink   (input valid, sample_time, status, output ready);
endinterface

// ----- rtl/core/itsamp_mem.sv -----
// Survival table memory: one write port, one registered read port.
module itsamp_mem (
   input  logic                          clock,
   input  itsamp_pkg::mem_req_type       mem_req,
   output logic [itsamp_pkg::ENTRY_W-1:0] rd_data
);
   import itsamp_pkg::*;

   logic [ENTRY_W-1:0] store_ff [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= store_ff[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/itsamp_arith.sv -----
// Shared arithmetic unit: registered multiplier and two-bit-per-cycle divider.
module itsamp_arith (
   input  logic                          clock,
   input  logic [itsamp_pkg::STEP_W-1:0] step_size,
   input  itsamp_pkg::arith_cmd_type     cmd,
   output itsamp_pkg::arith_res_type     res
);
   import itsamp_pkg::*;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [ENTRY_W-1:0] rem_ff, rem_in;
   logic [ENTRY_W-1:0] div_ff, div_in;

   logic [ENTRY_W:0]   trial1, trial2;
   logic [ENTRY_W-1:0] rem1;
   logic [QUO_W-1:0]   quo1;

   always_comb begin
      prod_in = prod_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial1  = {rem_ff, quo_ff[QUO_W-1]};
      quo1    = {quo_ff[QUO_W-2:0], 1'b0};
      rem1    = trial1[ENTRY_W-1:0];
      if (trial1 >= {1'b0, div_ff}) begin
         rem1    = ENTRY_W'(trial1 - {1'b0, div_ff});
         quo1[0] = 1'b1;
      end
      trial2 = {rem1, quo1[QUO_W-1]};
      unique case (cmd.op)
         ARITH_NOP: begin
         end
         ARITH_MUL: begin
            prod_in = PROD_W'(cmd.mul_a) * PROD_W'(step_size);
         end
         ARITH_DIV_START: begin
            quo_in = QUO_W'(prod_ff);
            rem_in = '0;
            div_in = cmd.divisor;
         end
         ARITH_DIV_STEP: begin
            quo_in = {quo1[QUO_W-2:0], 1'b0};
            rem_in = trial2[ENTRY_W-1:0];
            if (trial2 >= {1'b0, div_ff}) begin
               rem_in    = ENTRY_W'(trial2 - {1'b0, div_ff});
               quo_in[0] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign res.prod = prod_ff;
   assign res.quo  = quo_ff;
endmodule

// ----- rtl/core/itsamp_ctrl.sv -----
// Sequencer: table bookkeeping, binary search, interpolation control, response register.
module itsamp_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   itsamp_req_if.sink                     req_chan,
   itsamp_rsp_if.source                   rsp_chan,
   output itsamp_pkg::mem_req_type        mem_req,
   input  logic [itsamp_pkg::ENTRY_W-1:0] rd_data,
   output itsamp_pkg::arith_cmd_type      arith_cmd,
   input  itsamp_pkg::arith_res_type      arith_res
);
   import itsamp_pkg::*;

   function automatic logic [ADDR_W-1:0] mid_of(input logic [ADDR_W-1:0] h,
                                                input logic [ADDR_W-1:0] t);
      logic [ADDR_W:0] s;
      s = {1'b0, h} + {1'b0, t};
      return s[ADDR_W:1];
   endfunction

   function automatic logic adjacent(input logic [ADDR_W-1:0] h,
                                     input logic [ADDR_W-1:0] t);
      return ({1'b0, h} + (ADDR_W+1)'(1)) == {1'b0, t};
   endfunction

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  n_ff, n_in;
   logic                bad_ff, bad_in;
   logic [ENTRY_W-1:0]  last_ff, last_in;
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [ADDR_W-1:0]   tail_ff, tail_in;
   logic [ADDR_W-1:0]   mid_ff, mid_in;
   logic [ENTRY_W-1:0]  sh_ff, sh_in;
   logic [ENTRY_W-1:0]  st_ff, st_in;
   logic [DRAW_W-1:0]   p_ff, p_in;
   logic [PROD_W-1:0]   base_ff, base_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]   res_time_ff, res_time_in;
   status_type          res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic [ENTRY_W-1:0]  val_sat;
   logic [ENTRY_W-1:0]  p_ext;
   logic [COUNT_W-1:0]  last_idx;
   logic [ADDR_W-1:0]   mid_next;
   logic [SUM_W-1:0]    sum;

   assign val_sat  = (req_chan.entry_value > ENTRY_ONE) ? ENTRY_ONE : req_chan.entry_value;
   assign p_ext    = {1'b0, p_ff};
   assign last_idx = n_ff - COUNT_W'(1);
   assign sum      = {1'b0, base_ff} + SUM_W'(arith_res.quo);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      bad_in        = bad_ff;
      last_in       = last_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      mid_in        = mid_ff;
      sh_in         = sh_ff;
      st_in         = st_ff;
      p_in          = p_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      res_time_in   = res_time_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_status_in = rsp_status_ff;
      mid_next      = '0;
      mem_req       = '0;
      arith_cmd     = '{op: ARITH_NOP, mul_a: '0, divisor: '0};
      req_chan.ready = 1'b0;

      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               res_time_in   = '0;
               res_status_in = STATUS_OK;
               p_in          = req_chan.uniform_draw;
               state_in      = S_RESP;
               case (req_chan.cmd)
                  CMD_RESTART: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = '0;
                     mem_req.wr_data = val_sat;
                     n_in            = COUNT_W'(1);
                     bad_in          = 1'b0;
                     last_in         = val_sat;
                  end
                  CMD_APPEND: begin
                     if (n_ff >= COUNT_W'(TABLE_DEPTH)) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        if (n_ff != '0 && val_sat > last_ff) begin
                           bad_in        = 1'b1;
                           res_status_in = STATUS_NOT_DECR;
                        end
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = n_ff[ADDR_W-1:0];
                        mem_req.wr_data = val_sat;
                        n_in            = n_ff + COUNT_W'(1);
                        last_in         = val_sat;
                     end
                  end
                  CMD_SAMPLE: begin
                     if (bad_ff || n_ff < COUNT_W'(2)) begin
                        res_status_in = STATUS_BAD_TABLE;
                     end else begin
                        mem_req.rd_addr = '0;
                        state_in        = S_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIRST: begin
            sh_in = rd_data;
            if (p_ext > rd_data) begin
               state_in = S_RESP;
            end else begin
               mem_req.rd_addr = last_idx[ADDR_W-1:0];
               state_in        = S_LAST;
            end
         end
         S_LAST: begin
            st_in   = rd_data;
            head_in = '0;
            tail_in = last_idx[ADDR_W-1:0];
            if (p_ext < rd_data) begin
               arith_cmd.op    = ARITH_MUL;
               arith_cmd.mul_a = ENTRY_W'(n_ff);
               state_in        = S_CLAMP;
            end else if (adjacent(head_in, tail_in)) begin
               state_in = S_INTERP;
            end else begin
               mid_next        = mid_of(head_in, tail_in);
               mid_in          = mid_next;
               mem_req.rd_addr = mid_next;
               state_in        = S_SRCH;
            end
         end
         S_SRCH: begin
            if (p_ext < rd_data) begin
               head_in = mid_ff;
               sh_in   = rd_data;
            end else begin
               tail_in = mid_ff;
               st_in   = rd_data;
            end
            if (adjacent(head_in, tail_in)) begin
               state_in = S_INTERP;
            end else begin
               mid_next        = mid_of(head_in, tail_in);
               mid_in          = mid_next;
               mem_req.rd_addr = mid_next;
            end
         end
         S_INTERP: begin
            arith_cmd.op = ARITH_MUL;
            if (sh_ff <= st_ff) begin
               arith_cmd.mul_a = ENTRY_W'(tail_ff);
               state_in        = S_CLAMP;
            end else begin
               arith_cmd.mul_a = ENTRY_W'(head_ff);
               state_in        = S_BASE;
            end
         end
         S_BASE: begin
            base_in         = arith_res.prod;
            arith_cmd.op    = ARITH_MUL;
            arith_cmd.mul_a = sh_ff - p_ext;
            state_in        = S_DSTART;
         end
         S_DSTART: begin
            arith_cmd.op      = ARITH_DIV_START;
            arith_cmd.divisor = sh_ff - st_ff;
            cnt_in            = '0;
            state_in          = S_DIV;
         end
         S_DIV: begin
            arith_cmd.op = ARITH_DIV_STEP;
            cnt_in       = cnt_ff + DCNT_W'(1);
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            res_time_in = clamp_time(sum);
            state_in    = S_RESP;
         end
         S_CLAMP: begin
            res_time_in = clamp_time({1'b0, arith_res.prod});
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = res_time_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      mid_ff        <= mid_in;
      sh_ff         <= sh_in;
      st_ff         <= st_in;
      p_ff          <= p_in;
      base_ff       <= base_in;
      cnt_ff        <= cnt_in;
      res_time_ff   <= res_time_in;
      res_status_ff <= res_status_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sample_time = rsp_time_ff;
   assign rsp_chan.status      = rsp_status_ff;
endmodule

// ----- rtl/core/table_inverse_transform_sampler.sv -----
// Top level of the table inverse-transform sampler: CSR port and unit wiring.
//
// Usage:
//   req_chan carries one command per transaction: restart the survival table
//   with an entry, append an entry, or draw a sample from a Q0.16 uniform.
//   rsp_chan returns exactly one transaction per request: a Q.16 sample time
//   (zero for load commands) and a status code.
//   The CSR port holds step_size (Q16.16) at byte address 0; write it only
//   while the block is idle. pready is tied high.
// Sequence (accepting edge to rsp_chan.valid high):
//   Load commands, unused commands and rejected samples go straight to the
//   response register. A draw above the first entry ends after the first
//   read; one below the last entry after the last read and a multiply.
//   Interpolated: one read per binary-search step (ceil(log2(entries-1)),
//   at most 10), two multiplies, then the divide; a flat bracket: one multiply.
//   The single table read port and the shared multiply/divide unit set this.
//   One request is in flight at a time; req_chan.ready rises with the result.
// Reset: synchronous; empties the table, clears the bad flag and sets
//   step_size to 1.0. Table contents are not cleared.
// Stall: a finished result waits in the response register; the next result
//   is held in the sequencer, which stays busy until that register frees.
module table_inverse_transform_sampler (
   input  logic                              clock,
   input  logic                              reset,
   itsamp_req_if.sink                        req_chan,
   itsamp_rsp_if.source                      rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [itsamp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [itsamp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [itsamp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);
   import itsamp_pkg::*;

   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   mem_req_type          mem_req;
   logic [ENTRY_W-1:0]   rd_data;
   arith_cmd_type        arith_cmd;
   arith_res_type        arith_res;

   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;

   always_comb begin
      step_in = step_ff;
      if (psel && penable && pwrite && csr_idx == CSR_STEP_SIZE) begin
         step_in = STEP_W'(pwdata);
      end
      prdata = '0;
      if (csr_idx == CSR_STEP_SIZE) begin
         prdata = CSR_DATA_W'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   itsamp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .arith_cmd (arith_cmd),
      .arith_res (arith_res)
   );

   itsamp_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   itsamp_arith u_arith (
      .clock     (clock),
      .step_size (step_ff),
      .cmd       (arith_cmd),
      .res       (arith_res)
   );
endmodule

// ----- rtl/core/itsamp_check.sv -----
// Port-level assertions for the sampler and the bind that attaches them.
module itsamp_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [itsamp_pkg::TIME_W-1:0]   rsp_sample_time,
   input logic [itsamp_pkg::STATUS_W-1:0] rsp_status
);
   import itsamp_pkg::*;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready held high after an accepted transaction");

   a_error_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_sample_time == '0))
      else $error("nonzero time with error status");

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_sample_time) && $stable(rsp_status)))
      else $error("response payload changed while stalled");
endmodule

bind table_inverse_transform_sampler itsamp_check u_itsamp_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_sample_time (rsp_chan.sample_time),
   .rsp_status      (rsp_chan.status)
);
